### sv/assert_macros.svh
// Concurrent assertion macros for the seed key generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside of reset.
`define SKXG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SKXG_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

### sv/skxg_pkg.sv
// Shared widths, constants, command and status types of the seed key generator.
package skxg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned SelW   = 4;

  localparam logic [CountW-1:0] CountOfs = 7'h1F;

  localparam logic [WordW-1:0] KeyWords [16] = '{
    32'h14FA3579, 32'h27CD3964, 32'h1777FE32, 32'h9931AF12,
    32'h75DB3A49, 32'h19294CAA, 32'hFF18CD76, 32'h0788236D,
    32'h5A6F7CBB, 32'h7A992254, 32'hADFD5414, 32'h343CFBCB,
    32'hC2F51639, 32'h6A6D5813, 32'h3729FF68, 32'h22A2C751
  };

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } skxg_cmd_t;

  typedef struct packed {
    logic [CountW-1:0] init_count;
  } skxg_sts_t;

  function automatic logic [CountW-1:0] iter_count(input logic [WordW-1:0] s);
    logic [CountW-1:0] raw;
    raw = {s[0], 1'b0, s[9], s[1], s[11], s[2], s[5]};
    return raw + CountOfs;
  endfunction

  function automatic logic [SelW-1:0] table_sel(input logic [WordW-1:0] s);
    return {s[0], s[1], s[2], s[9]};
  endfunction

endpackage

### sv/skxg_if.sv
// Valid/ready channel interfaces for seed items and key items.
interface skxg_seed_if
  import skxg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

interface skxg_key_if
  import skxg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

### sv/skxg_datapath.sv
// Working word, selected table word and key output register.
module skxg_datapath
  import skxg_pkg::*;
(
  input  logic             clk_i,
  input  logic [WordW-1:0] seed_i,
  input  skxg_cmd_t        cmd_i,
  output skxg_sts_t        sts_o,
  output logic [WordW-1:0] key_o
);

  logic [WordW-1:0] word_q, word_d;
  logic [WordW-1:0] mask_q, mask_d;
  logic [WordW-1:0] key_q, key_d;
  logic [WordW-1:0] shifted;

  assign sts_o.init_count = iter_count(seed_i);
  assign shifted          = {word_q[WordW-2:0], 1'b0};

  always_comb begin
    word_d = word_q;
    mask_d = mask_q;
    key_d  = key_q;
    if (cmd_i.load) begin
      word_d = seed_i;
      mask_d = KeyWords[table_sel(seed_i)];
    end else if (cmd_i.step) begin
      word_d = word_q[WordW-1] ? (shifted ^ mask_q) : shifted;
    end
    if (cmd_i.capture) begin
      key_d = word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    mask_q <= mask_d;
    key_q  <= key_d;
  end

  assign key_o = key_q;

endmodule

### sv/skxg_ctrl.sv
// Sequencer: loads a seed, counts the shift-xor steps and hands off the key.
module skxg_ctrl
  import skxg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  skxg_sts_t sts_i,
  output skxg_cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = sts_i.init_count;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (cnt_q != '0) begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q - CountW'(1);
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/seed_key_shift_xor_generator.sv
// Seed key generator top level: sequencer plus shift-xor datapath.
//
// Usage: a 32-bit seed item enters on seed_i (valid/ready); one 32-bit key item
// leaves on key_o (valid/ready) for every seed taken.
// The seed is loaded in the accept cycle. The working word then doubles and
// conditionally XORs with a table word once per cycle, 31 to 126 times,
// the count being taken from seed bits 0, 9, 1, 11, 2 and 5. A capture then
// moves the word into the key output register.
// One seed is worked on at a time; seed_i.ready is low while the steps run
// and until the key is captured, so the single shift-xor unit takes no new
// seed before the key of the last one is registered.
// A new seed is taken while the previous key still waits on key_o.
// If the receiver stalls, the key holds; a finished computation then waits
// before capture until the output register is free.
// Reset (rst_ni, asynchronous, active low) returns to idle and drops
// key_o.valid; no item is in flight after reset.
`include "assert_macros.svh"

module seed_key_shift_xor_generator
  import skxg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  skxg_seed_if.sink          seed_i,
  skxg_key_if.source         key_o
);

  skxg_cmd_t ctrl_cmd;
  skxg_sts_t dp_sts;

  skxg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seed_i.valid),
    .in_ready_o  (seed_i.ready),
    .out_valid_o (key_o.valid),
    .out_ready_i (key_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  skxg_datapath u_datapath (
    .clk_i  (clk_i),
    .seed_i (seed_i.seed),
    .cmd_i  (ctrl_cmd),
    .sts_o  (dp_sts),
    .key_o  (key_o.key)
  );

  `SKXG_ASSERT_NEXT(a_busy_after_load, seed_i.valid && seed_i.ready, !seed_i.ready,
    "seed accepted but block still ready next cycle")
  `SKXG_ASSERT(a_capture_free, !ctrl_cmd.capture || !key_o.valid || key_o.ready,
    "key captured over an untaken key item")
  `SKXG_ASSERT(a_step_busy, !ctrl_cmd.step || !seed_i.ready,
    "step issued while idle")
  `SKXG_ASSERT_NEXT(a_capture_valid, ctrl_cmd.capture, key_o.valid && seed_i.ready,
    "capture did not raise key valid and return to idle")

endmodule
